// ----- src/jsu_pkg.sv -----
package jsu_pkg;

   // Default depth of the queue between the decoder and the result serializer.
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // Result status codes.
   localparam logic [3:0] ST_OK        = 4'd0;
   localparam logic [3:0] ST_NO_QUOTE  = 4'd1;
   localparam logic [3:0] ST_UNTERM    = 4'd2;
   localparam logic [3:0] ST_CONTROL   = 4'd3;
   localparam logic [3:0] ST_ESCAPE    = 4'd4;
   localparam logic [3:0] ST_HEX       = 4'd5;
   localparam logic [3:0] ST_SURROGATE = 4'd6;
   localparam logic [3:0] ST_NUL       = 4'd7;
   localparam logic [3:0] ST_UTF8      = 4'd8;

   // Decoder states.
   typedef enum logic [3:0] {
      MODE_IDLE,
      MODE_BODY,
      MODE_ESC,
      MODE_HEX,
      MODE_SUR_BS,
      MODE_SUR_U,
      MODE_HEX_LOW,
      MODE_UTF8,
      MODE_DRAIN
   } jsu_mode_type;

   // One queue entry: either one to four decoded bytes, or the final result of a string.
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      count;
      logic            is_last;
      logic [3:0]      status;
   } jsu_entry_type;

endpackage

// ----- src/jsu_front.sv -----
module jsu_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_in_byte,
   input  logic                  req_end_of_input,
   input  logic                  queue_full,
   output logic                  push,
   output jsu_pkg::jsu_entry_type push_entry
);

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_SLASH  = 8'h2f;
   localparam logic [7:0] CH_LOW_B  = 8'h62;
   localparam logic [7:0] CH_LOW_F  = 8'h66;
   localparam logic [7:0] CH_LOW_N  = 8'h6e;
   localparam logic [7:0] CH_LOW_R  = 8'h72;
   localparam logic [7:0] CH_LOW_T  = 8'h74;
   localparam logic [7:0] CH_LOW_U  = 8'h75;

   // Returns {is_hex, value}.
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

   function automatic logic [20:0] class_min(input logic [1:0] cls);
      logic [20:0] r;
      case (cls)
         2'd1:    r = 21'h80;
         2'd2:    r = 21'h800;
         2'd3:    r = 21'h10000;
         default: r = 21'h0;
      endcase
      return r;
   endfunction

   function automatic jsu_pkg::jsu_entry_type encode(input logic [20:0] n);
      jsu_pkg::jsu_entry_type e;
      e = '0;
      if (n < 21'h80) begin
         e.bytes[0] = n[7:0];
         e.count    = 3'd1;
      end else if (n < 21'h800) begin
         e.bytes[0] = {3'b110, n[10:6]};
         e.bytes[1] = {2'b10, n[5:0]};
         e.count    = 3'd2;
      end else if (n < 21'h10000) begin
         e.bytes[0] = {4'b1110, n[15:12]};
         e.bytes[1] = {2'b10, n[11:6]};
         e.bytes[2] = {2'b10, n[5:0]};
         e.count    = 3'd3;
      end else begin
         e.bytes[0] = {5'b11110, n[20:18]};
         e.bytes[1] = {2'b10, n[17:12]};
         e.bytes[2] = {2'b10, n[11:6]};
         e.bytes[3] = {2'b10, n[5:0]};
         e.count    = 3'd4;
      end
      return e;
   endfunction

   jsu_pkg::jsu_mode_type mode_ff, mode_in, step_mode;
   logic [20:0] acc_ff, acc_in;
   logic [9:0]  high_ff, high_in;
   logic [1:0]  hexcnt_ff, hexcnt_in;
   logic [1:0]  remain_ff, remain_in;
   logic [1:0]  class_ff, class_in;

   logic                   accept;
   logic                   fault;
   logic                   closing;
   logic                   finishing;
   logic [3:0]             fault_code;
   jsu_pkg::jsu_entry_type emitted;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   // Per-byte classification and data register updates.
   always_comb begin : classify
      logic [4:0]  hv;
      logic [15:0] acc16;
      logic [20:0] acc21;
      logic [1:0]  rem_next;
      logic [20:0] pair;
      hv         = hex_value(req_in_byte);
      acc16      = {acc_ff[11:0], hv[3:0]};
      acc21      = {acc_ff[14:0], req_in_byte[5:0]};
      rem_next   = remain_ff - 2'd1;
      pair       = {11'({1'b0, high_ff}) + 11'h40, acc16[9:0]};
      step_mode  = mode_ff;
      fault      = 1'b0;
      closing    = 1'b0;
      fault_code = jsu_pkg::ST_OK;
      emitted    = '0;
      acc_in     = acc_ff;
      high_in    = high_ff;
      hexcnt_in  = hexcnt_ff;
      remain_in  = remain_ff;
      class_in   = class_ff;
      case (mode_ff)
         jsu_pkg::MODE_DRAIN: begin
         end
         jsu_pkg::MODE_BODY: begin
            if (req_in_byte == CH_QUOTE) begin
               closing = 1'b1;
            end else if (req_in_byte < 8'h20) begin
               fault      = 1'b1;
               fault_code = jsu_pkg::ST_CONTROL;
            end else if (req_in_byte == CH_BSLASH) begin
               step_mode = jsu_pkg::MODE_ESC;
            end else if (req_in_byte < 8'h80) begin
               emitted.bytes[0] = req_in_byte;
               emitted.count    = 3'd1;
            end else if (req_in_byte >= 8'hc2 && req_in_byte <= 8'hdf) begin
               remain_in = 2'd1;
               class_in  = 2'd1;
               acc_in    = {16'd0, req_in_byte[4:0]};
               emitted.bytes[0] = req_in_byte;
               emitted.count    = 3'd1;
               step_mode = jsu_pkg::MODE_UTF8;
            end else if (req_in_byte >= 8'he0 && req_in_byte <= 8'hef) begin
               remain_in = 2'd2;
               class_in  = 2'd2;
               acc_in    = {17'd0, req_in_byte[3:0]};
               emitted.bytes[0] = req_in_byte;
               emitted.count    = 3'd1;
               step_mode = jsu_pkg::MODE_UTF8;
            end else if (req_in_byte >= 8'hf0 && req_in_byte <= 8'hf4) begin
               remain_in = 2'd3;
               class_in  = 2'd3;
               acc_in    = {18'd0, req_in_byte[2:0]};
               emitted.bytes[0] = req_in_byte;
               emitted.count    = 3'd1;
               step_mode = jsu_pkg::MODE_UTF8;
            end else begin
               fault      = 1'b1;
               fault_code = jsu_pkg::ST_UTF8;
            end
         end
         jsu_pkg::MODE_UTF8: begin
            if (req_in_byte[7:6] != 2'b10) begin
               fault      = 1'b1;
               fault_code = jsu_pkg::ST_UTF8;
            end else begin
               emitted.bytes[0] = req_in_byte;
               emitted.count    = 3'd1;
               acc_in    = acc21;
               remain_in = rem_next;
               if (rem_next == 2'd0) begin
                  if (acc21 < class_min(class_ff) || acc21 > 21'h10ffff ||
                      (acc21 >= 21'hd800 && acc21 <= 21'hdfff)) begin
                     fault      = 1'b1;
                     fault_code = jsu_pkg::ST_UTF8;
                  end else begin
                     step_mode = jsu_pkg::MODE_BODY;
                  end
               end
            end
         end
         jsu_pkg::MODE_ESC: begin
            step_mode = jsu_pkg::MODE_BODY;
            emitted.count = 3'd1;
            if (req_in_byte == CH_QUOTE || req_in_byte == CH_BSLASH ||
                req_in_byte == CH_SLASH) begin
               emitted.bytes[0] = req_in_byte;
            end else if (req_in_byte == CH_LOW_B) begin
               emitted.bytes[0] = 8'h08;
            end else if (req_in_byte == CH_LOW_F) begin
               emitted.bytes[0] = 8'h0c;
            end else if (req_in_byte == CH_LOW_N) begin
               emitted.bytes[0] = 8'h0a;
            end else if (req_in_byte == CH_LOW_R) begin
               emitted.bytes[0] = 8'h0d;
            end else if (req_in_byte == CH_LOW_T) begin
               emitted.bytes[0] = 8'h09;
            end else if (req_in_byte == CH_LOW_U) begin
               emitted.count = 3'd0;
               step_mode     = jsu_pkg::MODE_HEX;
               acc_in        = '0;
               hexcnt_in     = 2'd0;
            end else begin
               emitted.count = 3'd0;
               fault         = 1'b1;
               fault_code    = jsu_pkg::ST_ESCAPE;
            end
         end
         jsu_pkg::MODE_HEX, jsu_pkg::MODE_HEX_LOW: begin
            if (!hv[4]) begin
               fault      = 1'b1;
               fault_code = jsu_pkg::ST_HEX;
            end else begin
               acc_in = {5'd0, acc16};
               if (hexcnt_ff != 2'd3) begin
                  hexcnt_in = hexcnt_ff + 2'd1;
               end else begin
                  hexcnt_in = 2'd0;
                  if (mode_ff == jsu_pkg::MODE_HEX_LOW) begin
                     if (acc16 < 16'hdc00 || acc16 > 16'hdfff) begin
                        fault      = 1'b1;
                        fault_code = jsu_pkg::ST_SURROGATE;
                     end else begin
                        emitted   = encode(pair);
                        step_mode = jsu_pkg::MODE_BODY;
                     end
                  end else if (acc16 >= 16'hd800 && acc16 <= 16'hdbff) begin
                     high_in   = acc16[9:0];
                     step_mode = jsu_pkg::MODE_SUR_BS;
                  end else if (acc16 >= 16'hdc00 && acc16 <= 16'hdfff) begin
                     fault      = 1'b1;
                     fault_code = jsu_pkg::ST_SURROGATE;
                  end else if (acc16 == 16'd0) begin
                     fault      = 1'b1;
                     fault_code = jsu_pkg::ST_NUL;
                  end else begin
                     emitted   = encode({5'd0, acc16});
                     step_mode = jsu_pkg::MODE_BODY;
                  end
               end
            end
         end
         jsu_pkg::MODE_SUR_BS: begin
            if (req_in_byte == CH_BSLASH) begin
               step_mode = jsu_pkg::MODE_SUR_U;
            end else begin
               fault      = 1'b1;
               fault_code = jsu_pkg::ST_SURROGATE;
            end
         end
         jsu_pkg::MODE_SUR_U: begin
            if (req_in_byte == CH_LOW_U) begin
               step_mode = jsu_pkg::MODE_HEX_LOW;
               acc_in    = '0;
               hexcnt_in = 2'd0;
            end else begin
               fault      = 1'b1;
               fault_code = jsu_pkg::ST_SURROGATE;
            end
         end
         default: begin
            if (req_in_byte == CH_QUOTE) begin
               step_mode = jsu_pkg::MODE_BODY;
            end else begin
               fault      = 1'b1;
               fault_code = jsu_pkg::ST_NO_QUOTE;
            end
         end
      endcase
   end

   assign finishing = (mode_ff != jsu_pkg::MODE_DRAIN) &&
                      (fault || closing || req_end_of_input);

   // Next state.
   always_comb begin
      mode_in = mode_ff;
      if (accept) begin
         if (mode_ff == jsu_pkg::MODE_DRAIN) begin
            mode_in = req_end_of_input ? jsu_pkg::MODE_IDLE : jsu_pkg::MODE_DRAIN;
         end else if (finishing) begin
            mode_in = ((closing && !fault) || req_end_of_input) ?
                      jsu_pkg::MODE_IDLE : jsu_pkg::MODE_DRAIN;
         end else begin
            mode_in = step_mode;
         end
      end
   end

   // Outputs toward the queue.
   always_comb begin
      push       = 1'b0;
      push_entry = emitted;
      if (finishing) begin
         push_entry         = '0;
         push_entry.is_last = 1'b1;
         push_entry.status  = fault ? fault_code :
                              (closing ? jsu_pkg::ST_OK : jsu_pkg::ST_UNTERM);
      end
      if (accept && mode_ff != jsu_pkg::MODE_DRAIN) begin
         push = finishing || (emitted.count != 3'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= jsu_pkg::MODE_IDLE;
         acc_ff    <= '0;
         high_ff   <= '0;
         hexcnt_ff <= '0;
         remain_ff <= '0;
         class_ff  <= '0;
      end else begin
         mode_ff <= mode_in;
         if (accept) begin
            acc_ff    <= acc_in;
            high_ff   <= high_in;
            hexcnt_ff <= hexcnt_in;
            remain_ff <= remain_in;
            class_ff  <= class_in;
         end
      end
   end

endmodule

// ----- src/jsu_queue.sv -----
module jsu_queue #(
   parameter int DEPTH = jsu_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  jsu_pkg::jsu_entry_type push_entry,
   output logic                   full,
   input  logic                   pop,
   output logic                   head_valid,
   output jsu_pkg::jsu_entry_type head_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   jsu_pkg::jsu_entry_type slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slots_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ff] <= push_entry;
      end
   end

endmodule

// ----- src/jsu_back.sv -----
module jsu_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   head_valid,
   input  jsu_pkg::jsu_entry_type head_entry,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_byte_valid,
   output logic [3:0]             rsp_status,
   output logic                   rsp_last
);

   jsu_pkg::jsu_entry_type cur_ff;
   logic                   valid_ff, valid_in;
   logic [1:0]             idx_ff, idx_in;
   logic                   entry_done;

   assign entry_done = cur_ff.is_last || ({1'b0, idx_ff} == cur_ff.count - 3'd1);
   assign pop        = head_valid && (!valid_ff || (rsp_ready && entry_done));

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (pop) begin
         valid_in = 1'b1;
         idx_in   = 2'd0;
      end else if (valid_ff && rsp_ready) begin
         if (entry_done) begin
            valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= head_entry;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_byte   = cur_ff.is_last ? 8'd0 : cur_ff.bytes[idx_ff];
   assign rsp_byte_valid = !cur_ff.is_last;
   assign rsp_status     = cur_ff.is_last ? cur_ff.status : jsu_pkg::ST_OK;
   assign rsp_last       = cur_ff.is_last;

endmodule

// ----- src/json_string_unescape_utf8_check.sv -----
// JSON string decoder with strict UTF-8 checking. Feed the bytes of one string literal,
// opening quote first, one byte per transfer on the req_ channel; the rsp_ channel returns
// the decoded UTF-8 bytes (rsp_byte_valid high) and then one final transfer with rsp_last
// high and rsp_status giving ok or the first error found. After an error, input is dropped
// until a byte marked with req_end_of_input, and the block then waits for a new opening
// quote. The decoder takes one input byte per cycle as long as the result queue has room;
// the serializer behind the queue sends one result per cycle while rsp_ready is high, so an
// escape that expands to two, three or four UTF-8 bytes is sent as one result per byte, and
// the input stalls only once the QUEUE_DEPTH-entry queue between the two has filled. Each
// result passes through the queue and then the serializer's output register.
module json_string_unescape_utf8_check #(
   parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_input,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic [3:0] rsp_status,
   output logic       rsp_last
);

   // Each decoded input byte becomes one queue entry: up to four output bytes, or a final
   // status. Bytes that produce nothing (a backslash, hex digits) do not touch the queue.
   logic                   queue_full;
   logic                   push;
   jsu_pkg::jsu_entry_type push_entry;
   logic                   pop;
   logic                   head_valid;
   jsu_pkg::jsu_entry_type head_entry;

   jsu_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_byte      (req_in_byte),
      .req_end_of_input (req_end_of_input),
      .queue_full       (queue_full),
      .push             (push),
      .push_entry       (push_entry)
   );

   jsu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   // The serializer walks through one entry a result at a time.
   jsu_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_entry     (head_entry),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last)
   );

endmodule

// ----- src/jsu_checker.sv -----
module jsu_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_byte_valid,
   input logic [3:0] rsp_status,
   input logic       rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) &&
         $stable(rsp_last) && $stable(rsp_status))
      else $error("result changed while stalled");

   a_byte_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_valid |-> !rsp_last && rsp_status == jsu_pkg::ST_OK)
      else $error("decoded byte carries status or last");

   a_final_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_last && rsp_out_byte == 8'd0 &&
         rsp_status <= jsu_pkg::ST_UTF8)
      else $error("malformed final result");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not empty right after reset");

endmodule

bind json_string_unescape_utf8_check jsu_checker u_jsu_checker (.*);

// ----- bench/tb_json_string_unescape_utf8_check.sv -----
`timescale 1ns / 1ps

// Bench for the JSON string decoder. Byte streams are pushed through the req_ channel
// with random gaps and every accepted transfer is run through a behavioral decoder in
// this module, which queues the results the block should return. A checker pops that
// queue on every rsp_ transfer and compares all four result fields.
module tb_json_string_unescape_utf8_check;

   localparam int HALF_PERIOD     = 4;
   localparam int RESET_CYCLES    = 5;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int WATCHDOG_LIMIT  = 1000;
   localparam int DRAIN_CYCLES    = 16;
   localparam int RANDOM_ITEMS    = 210;
   localparam int MAX_REPORTS     = 10;

   // One result as the block should present it on the rsp_ channel.
   typedef struct packed {
      logic [7:0] data;
      logic       byte_flag;
      logic [3:0] code;
      logic       fin;
   } rsp_fields_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_in_byte;
   logic       req_end_of_input;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_out_byte;
   logic       rsp_byte_valid;
   logic [3:0] rsp_status;
   logic       rsp_last;

   // Results still owed by the block, oldest first.
   rsp_fields_type pending_rsp[$];
   // Bytes of the string being assembled by the stimulus generators.
   logic [7:0]  text_q[$];

   int    mismatches  = 0;
   int    items_sent  = 0;
   int    idle_cycles = 0;
   bit    tx_no_idle  = 1'b0;
   bit    hold_off_req = 1'b0;
   string esc_letters = "\"\\/bfnrt";

   // Decoder state mirrored by the bench.
   jsu_pkg::jsu_mode_type dec_mode;
   logic [20:0]  cp_accum;
   logic [9:0]   hi_half;
   logic [1:0]   hex_cnt;
   logic [1:0]   u8_left;
   logic [1:0]   u8_class;

   json_string_unescape_utf8_check dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_byte      (req_in_byte),
      .req_end_of_input (req_end_of_input),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Mostly short gaps, now and then a long one.
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic int hex_value(input logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "a" && c <= "f") return c - "a" + 10;
      if (c >= "A" && c <= "F") return c - "A" + 10;
      return -1;
   endfunction

   // UTF-8 encoding of a scalar value; returns the number of bytes.
   function automatic int utf8_encode(input logic [20:0] n, output logic [3:0][7:0] enc);
      enc = '0;
      if (n < 21'h80) begin
         enc[0] = n[7:0];
         return 1;
      end
      if (n < 21'h800) begin
         enc[0] = {3'b110, n[10:6]};
         enc[1] = {2'b10, n[5:0]};
         return 2;
      end
      if (n < 21'h10000) begin
         enc[0] = {4'b1110, n[15:12]};
         enc[1] = {2'b10, n[11:6]};
         enc[2] = {2'b10, n[5:0]};
         return 3;
      end
      enc[0] = {5'b11110, n[20:18]};
      enc[1] = {2'b10, n[17:12]};
      enc[2] = {2'b10, n[11:6]};
      enc[3] = {2'b10, n[5:0]};
      return 4;
   endfunction

   // Advances the mirrored decoder by one accepted byte and queues what the block owes.
   // A byte that ends the string (closing quote or any error) yields only the final
   // result; decoded bytes of that same byte are discarded.
   task automatic decode_byte(input logic [7:0] b, input logic eoi);
      logic [3:0][7:0] dec_bytes;
      int              nb;
      int              d;
      int              i;
      logic            ends_string;
      logic            wait_low;
      logic [3:0]      end_code;
      logic [20:0]     n;
      logic [20:0]     min_code;
      dec_bytes   = '0;
      nb          = 0;
      ends_string = 1'b0;
      wait_low    = 1'b0;
      end_code    = jsu_pkg::ST_OK;
      n           = '0;
      // After an error everything is dropped until a byte carries the end mark.
      if (dec_mode == jsu_pkg::MODE_DRAIN) begin
         if (eoi) dec_mode = jsu_pkg::MODE_IDLE;
         return;
      end
      case (dec_mode)
         jsu_pkg::MODE_BODY: begin
            if (b == "\"") begin
               ends_string = 1'b1;
               end_code    = jsu_pkg::ST_OK;
            end else if (b < 8'h20) begin
               ends_string = 1'b1;
               end_code    = jsu_pkg::ST_CONTROL;
            end else if (b == "\\") begin
               dec_mode = jsu_pkg::MODE_ESC;
            end else if (b < 8'h80) begin
               dec_bytes[0] = b;
               nb           = 1;
            end else if (b >= 8'hc2 && b <= 8'hf4) begin
               // Lead byte: the number of continuation bytes also picks the
               // smallest value that is not overlong.
               if (b < 8'he0) begin
                  u8_left  = 2'd1;
                  cp_accum = 21'(b[4:0]);
               end else if (b < 8'hf0) begin
                  u8_left  = 2'd2;
                  cp_accum = 21'(b[3:0]);
               end else begin
                  u8_left  = 2'd3;
                  cp_accum = 21'(b[2:0]);
               end
               u8_class     = u8_left;
               dec_bytes[0] = b;
               nb           = 1;
               dec_mode     = jsu_pkg::MODE_UTF8;
            end else begin
               ends_string = 1'b1;
               end_code    = jsu_pkg::ST_UTF8;
            end
         end
         jsu_pkg::MODE_UTF8: begin
            if (b[7:6] != 2'b10) begin
               ends_string = 1'b1;
               end_code    = jsu_pkg::ST_UTF8;
            end else begin
               dec_bytes[0] = b;
               nb           = 1;
               cp_accum     = {cp_accum[14:0], b[5:0]};
               u8_left      = u8_left - 2'd1;
               if (u8_left == 2'd0) begin
                  case (u8_class)
                     2'd1:    min_code = 21'h80;
                     2'd2:    min_code = 21'h800;
                     2'd3:    min_code = 21'h10000;
                     default: min_code = 21'h0;
                  endcase
                  if (cp_accum < min_code || cp_accum > 21'h10ffff ||
                      (cp_accum >= 21'h0d800 && cp_accum <= 21'h0dfff)) begin
                     ends_string = 1'b1;
                     end_code    = jsu_pkg::ST_UTF8;
                  end else begin
                     dec_mode = jsu_pkg::MODE_BODY;
                  end
               end
            end
         end
         jsu_pkg::MODE_ESC: begin
            dec_mode     = jsu_pkg::MODE_BODY;
            dec_bytes[0] = b;
            nb           = 1;
            case (b)
               "\"", "\\", "/": ;
               "b": dec_bytes[0] = 8'h08;
               "f": dec_bytes[0] = 8'h0c;
               "n": dec_bytes[0] = 8'h0a;
               "r": dec_bytes[0] = 8'h0d;
               "t": dec_bytes[0] = 8'h09;
               "u": begin
                  nb       = 0;
                  dec_mode = jsu_pkg::MODE_HEX;
                  cp_accum = '0;
                  hex_cnt  = 2'd0;
               end
               default: begin
                  nb          = 0;
                  ends_string = 1'b1;
                  end_code    = jsu_pkg::ST_ESCAPE;
               end
            endcase
         end
         jsu_pkg::MODE_HEX, jsu_pkg::MODE_HEX_LOW: begin
            d = hex_value(b);
            if (d < 0) begin
               ends_string = 1'b1;
               end_code    = jsu_pkg::ST_HEX;
            end else begin
               cp_accum = {5'b0, cp_accum[11:0], 4'(d)};
               if (hex_cnt != 2'd3) begin
                  hex_cnt = hex_cnt + 2'd1;
               end else begin
                  hex_cnt = 2'd0;
                  n       = cp_accum;
                  if (dec_mode == jsu_pkg::MODE_HEX_LOW) begin
                     // Second half of a pair: must be a low surrogate.
                     if (n < 21'h0dc00 || n > 21'h0dfff) begin
                        ends_string = 1'b1;
                        end_code    = jsu_pkg::ST_SURROGATE;
                     end else begin
                        n = 21'h10000 + {hi_half, 10'b0} + (n - 21'h0dc00);
                     end
                  end else if (n >= 21'h0d800 && n <= 21'h0dbff) begin
                     hi_half  = n[9:0];
                     dec_mode = jsu_pkg::MODE_SUR_BS;
                     wait_low = 1'b1;
                  end else if (n >= 21'h0dc00 && n <= 21'h0dfff) begin
                     ends_string = 1'b1;
                     end_code    = jsu_pkg::ST_SURROGATE;
                  end
                  if (!ends_string && !wait_low) begin
                     if (n == 21'h0) begin
                        ends_string = 1'b1;
                        end_code    = jsu_pkg::ST_NUL;
                     end else begin
                        nb       = utf8_encode(n, dec_bytes);
                        dec_mode = jsu_pkg::MODE_BODY;
                     end
                  end
               end
            end
         end
         jsu_pkg::MODE_SUR_BS: begin
            if (b == "\\") begin
               dec_mode = jsu_pkg::MODE_SUR_U;
            end else begin
               ends_string = 1'b1;
               end_code    = jsu_pkg::ST_SURROGATE;
            end
         end
         jsu_pkg::MODE_SUR_U: begin
            if (b == "u") begin
               dec_mode = jsu_pkg::MODE_HEX_LOW;
               cp_accum = '0;
               hex_cnt  = 2'd0;
            end else begin
               ends_string = 1'b1;
               end_code    = jsu_pkg::ST_SURROGATE;
            end
         end
         default: begin
            if (b == "\"") begin
               dec_mode = jsu_pkg::MODE_BODY;
            end else begin
               ends_string = 1'b1;
               end_code    = jsu_pkg::ST_NO_QUOTE;
            end
         end
      endcase

      // The end mark inside an open string is an error of its own.
      if (!ends_string && eoi) begin
         ends_string = 1'b1;
         end_code    = jsu_pkg::ST_UNTERM;
      end

      if (ends_string) begin
         pending_rsp.push_back('{data: 8'h00, byte_flag: 1'b0, code: end_code, fin: 1'b1});
         if (end_code == jsu_pkg::ST_OK || eoi) dec_mode = jsu_pkg::MODE_IDLE;
         else dec_mode = jsu_pkg::MODE_DRAIN;
      end else begin
         for (i = 0; i < nb; i++)
            pending_rsp.push_back('{data: dec_bytes[i], byte_flag: 1'b1,
                                    code: jsu_pkg::ST_OK, fin: 1'b0});
      end
   endtask

   function automatic void note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("mismatch %0d at %0t: %s", mismatches, $time, msg);
   endfunction

   // Offers one byte and returns at the rising edge where it was transferred. The payload
   // changes on the falling edge, so the byte is never offered twice.
   task automatic send_byte(input logic [7:0] b, input logic eoi);
      int gap;
      gap = tx_no_idle ? 0 : idle_len();
      @(negedge clock);
      if (gap > 0) begin
         req_valid        <= 1'b0;
         req_in_byte      <= 8'($urandom);
         req_end_of_input <= 1'($urandom);
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_in_byte      <= b;
      req_end_of_input <= eoi;
      do @(posedge clock); while (req_ready !== 1'b1);
      items_sent++;
      decode_byte(b, eoi);
   endtask

   // Sends the assembled string; the end mark goes on its last byte if asked.
   task automatic send_text(input bit eoi_last);
      int i;
      for (i = 0; i < text_q.size(); i++) send_byte(text_q[i], eoi_last && i == text_q.size() - 1);
      text_q.delete();
   endtask

   // Stops offering and waits until the block has returned everything it owes.
   task automatic wait_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   function automatic void add_str(input string s);
      int i;
      for (i = 0; i < s.len(); i++) text_q.push_back(s[i]);
   endfunction

   // Hex digit in random letter case.
   function automatic logic [7:0] hex_char(input logic [3:0] v);
      logic upper;
      upper = 1'($urandom_range(0, 1));
      if (v < 4'd10) return 8'h30 + v;
      return (upper ? 8'h41 : 8'h61) + v - 8'd10;
   endfunction

   function automatic void add_hex4(input logic [15:0] v);
      int k;
      add_str("\\u");
      for (k = 3; k >= 0; k--) text_q.push_back(hex_char(v[k*4 +: 4]));
   endfunction

   function automatic void add_raw(input logic [20:0] n);
      logic [3:0][7:0] enc;
      int              cnt;
      int              i;
      cnt = utf8_encode(n, enc);
      for (i = 0; i < cnt; i++) text_q.push_back(enc[i]);
   endfunction

   function automatic logic [7:0] cont_byte();
      return {2'b10, 6'($urandom_range(0, 63))};
   endfunction

   // A value from 0x800 to 0xFFFF that is not a surrogate.
   function automatic logic [15:0] bmp_upper();
      logic [15:0] v;
      v = 16'($urandom_range(16'h800, 16'hffff));
      if (v >= 16'hd800 && v <= 16'hdfff) v = v ^ 16'h8000;
      return v;
   endfunction

   // One well-formed piece of string content.
   function automatic void add_good_token();
      logic [7:0] c;
      int         r;
      r = $urandom_range(0, 99);
      if (r < 30) begin
         c = 8'($urandom_range(8'h20, 8'h7e));
         if (c == "\"" || c == "\\") c = "q";
         text_q.push_back(c);
      end else if (r < 45) begin
         text_q.push_back("\\");
         text_q.push_back(esc_letters[$urandom_range(0, 7)]);
      end else if (r < 60) begin
         case ($urandom_range(0, 2))
            0:       add_hex4(16'($urandom_range(1, 16'h7f)));
            1:       add_hex4(16'($urandom_range(16'h80, 16'h7ff)));
            default: add_hex4(bmp_upper());
         endcase
      end else if (r < 72) begin
         add_hex4(16'hd800 + 16'($urandom_range(0, 16'h3ff)));
         add_hex4(16'hdc00 + 16'($urandom_range(0, 16'h3ff)));
      end else begin
         case ($urandom_range(0, 2))
            0:       add_raw(21'($urandom_range(21'h80, 21'h7ff)));
            1:       add_raw(21'(bmp_upper()));
            default: add_raw(21'($urandom_range(21'h10000, 21'h10ffff)));
         endcase
      end
   endfunction

   // One piece of content that breaks the string in some way.
   function automatic void add_bad_token();
      int k;
      case ($urandom_range(0, 7))
         0: text_q.push_back(8'($urandom_range(0, 255)));
         1: text_q.push_back(8'($urandom_range(0, 8'h1f)));
         2: begin
            text_q.push_back("\\");
            text_q.push_back(8'($urandom_range(0, 255)));
         end
         3: begin
            // Escape with digits that are often not hex.
            add_str("\\u");
            for (k = 0; k < 4; k++) begin
               if ($urandom_range(0, 4) == 0) text_q.push_back(8'($urandom_range(0, 255)));
               else text_q.push_back(hex_char(4'($urandom_range(0, 15))));
            end
         end
         4: add_hex4(16'hdc00 + 16'($urandom_range(0, 16'h3ff)));
         5: begin
            // High surrogate that is not followed by a proper low half.
            add_hex4(16'hd800 + 16'($urandom_range(0, 16'h3ff)));
            case ($urandom_range(0, 2))
               0: text_q.push_back(8'($urandom_range(8'h20, 8'h7e)));
               1: begin
                  text_q.push_back("\\");
                  text_q.push_back(8'($urandom_range(0, 255)));
               end
               default: add_hex4(16'($urandom_range(0, 16'hdbff)));
            endcase
         end
         6: add_hex4(16'h0000);
         default: begin
            case ($urandom_range(0, 5))
               0: text_q.push_back(8'($urandom_range(8'h80, 8'hc1)));
               1: text_q.push_back(8'($urandom_range(8'hf5, 8'hff)));
               2: begin
                  // Overlong three-byte form.
                  text_q.push_back(8'he0);
                  text_q.push_back(8'($urandom_range(8'h80, 8'h9f)));
                  text_q.push_back(cont_byte());
               end
               3: begin
                  // Surrogate encoded as raw bytes.
                  text_q.push_back(8'hed);
                  text_q.push_back(8'($urandom_range(8'ha0, 8'hbf)));
                  text_q.push_back(cont_byte());
               end
               4: begin
                  // Overlong four-byte form, or a value past U+10FFFF.
                  if ($urandom_range(0, 1) == 0) begin
                     text_q.push_back(8'hf0);
                     text_q.push_back(8'($urandom_range(8'h80, 8'h8f)));
                  end else begin
                     text_q.push_back(8'hf4);
                     text_q.push_back(8'($urandom_range(8'h90, 8'hbf)));
                  end
                  text_q.push_back(cont_byte());
                  text_q.push_back(cont_byte());
               end
               default: begin
                  // Lead byte followed by something that is not a continuation.
                  text_q.push_back(8'($urandom_range(8'hc2, 8'hf4)));
                  if ($urandom_range(0, 1) == 0) text_q.push_back(8'($urandom_range(0, 8'h7f)));
                  else text_q.push_back(8'($urandom_range(8'hc0, 8'hff)));
               end
            endcase
         end
      endcase
   endfunction

   // Builds and sends one string. Most are well formed with random content; some carry
   // one broken piece, some lack the opening or closing quote, and a few are pure noise.
   task automatic send_random_string();
      int ntok;
      int bad_at;
      int k;
      int ending;
      text_q.delete();
      tx_no_idle = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 19) == 0) begin
         repeat ($urandom_range(1, 4)) text_q.push_back(8'($urandom_range(0, 255)));
         send_text(1'($urandom_range(0, 1)));
         return;
      end
      if ($urandom_range(0, 19) == 0) text_q.push_back(8'($urandom_range(0, 255)));
      else text_q.push_back("\"");
      ntok   = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) : $urandom_range(0, 6);
      bad_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, ntok) : -1;
      for (k = 0; k <= ntok; k++) begin
         if (k == bad_at) add_bad_token();
         else if (k < ntok) add_good_token();
      end
      ending = $urandom_range(0, 9);
      if (ending < 8) begin
         text_q.push_back("\"");
         send_text(1'($urandom_range(0, 1)));
      end else begin
         // Either cut off by the end mark, or left open so the next string runs on.
         send_text(ending == 8);
      end
   endtask

   // A few hand-picked strings at the edges: missing quote, an escape, the largest
   // surrogate pair, the largest raw sequence cut by the end mark, the lowest control
   // byte followed by dropped input, and the highest byte value as a bad lead.
   task automatic test_directed_strings();
      tx_no_idle = 1'b0;
      add_str("x");
      send_text(1'b1);
      add_str("\"\\/\"");
      send_text(1'b0);
      add_str("\"\\uDBFF\\udfff\"");
      send_text(1'b1);
      text_q = '{8'h22, 8'hf4, 8'h8f, 8'hbf, 8'hbf};
      send_text(1'b1);
      text_q = '{8'h22, 8'h00, 8'h7a};
      send_text(1'b1);
      text_q = '{8'h22, 8'hff};
      send_text(1'b1);
      wait_results();
   endtask

   task automatic test_random_strings();
      int target;
      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         send_random_string();
         // Occasionally let the block run dry so pauses land in every state.
         if ($urandom_range(0, 14) == 0) wait_results();
      end
      wait_results();
   endtask

   // The receiver holds off while a string of surrogate pairs and raw multi-byte sequences
   // streams in without gaps, so the result queue fills and the input stalls. The sender then
   // waits until everything has come back before sending one more string.
   task automatic test_backpressure();
      tx_no_idle   = 1'b1;
      hold_off_req = 1'b1;
      text_q.push_back("\"");
      repeat (4) begin
         add_hex4(16'hd800 + 16'($urandom_range(0, 16'h3ff)));
         add_hex4(16'hdc00 + 16'($urandom_range(0, 16'h3ff)));
      end
      add_raw(21'h10ffff);
      add_raw(21'h800);
      add_raw(21'h7ff);
      text_q.push_back("\"");
      send_text(1'b1);
      wait_results();
      add_str("\"ok\\n\"");
      send_text(1'b1);
      wait_results();
   endtask

   // Receiver: random stalls, calm stretches of steady ready, and the long hold-off on
   // request. It drives rsp_ready on falling edges only.
   initial begin : receiver
      int stall;
      int calm;
      stall     = 0;
      calm      = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_ready   <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            rsp_ready   <= 1'b1;
         end else if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else begin
            rsp_ready <= 1'b1;
            if (calm > 0) begin
               calm--;
            end else begin
               stall = idle_len();
               if ($urandom_range(0, 49) == 0) calm = 40;
            end
         end
      end
   end

   // Checks every rsp_ transfer against the oldest owed result.
   always @(posedge clock) begin : rsp_check
      rsp_fields_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (pending_rsp.size() == 0) begin
            note_mismatch($sformatf("unexpected result byte %02h valid %0b status %0d last %0b",
                                    rsp_out_byte, rsp_byte_valid, rsp_status, rsp_last));
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_out_byte !== want.data || rsp_byte_valid !== want.byte_flag ||
                rsp_status !== want.code || rsp_last !== want.fin)
               note_mismatch($sformatf(
                  "expected byte %02h valid %0b status %0d last %0b, got %02h %0b %0d %0b",
                  want.data, want.byte_flag, want.code, want.fin,
                  rsp_out_byte, rsp_byte_valid, rsp_status, rsp_last));
         end
      end
   end

   // Ends the run if neither channel completes a transfer for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_in_byte      = 8'h00;
      req_end_of_input = 1'b0;
      dec_mode         = jsu_pkg::MODE_IDLE;
      cp_accum         = '0;
      hi_half          = '0;
      hex_cnt          = '0;
      u8_left          = '0;
      u8_class         = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_strings();
      test_random_strings();
      test_backpressure();

      // Anything the block emits from here on has no owed result and is flagged.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
src/jsu_pkg.sv
src/jsu_front.sv
src/jsu_queue.sv
src/jsu_back.sv
src/json_string_unescape_utf8_check.sv
src/jsu_checker.sv
bench/tb_json_string_unescape_utf8_check.sv
